/* hw/rtl/psf1_text_glyph_renderer_defines.svh */
// Assertion macros for the glyph renderer
`ifndef PSF1_TEXT_GLYPH_RENDERER_DEFINES_SVH
`define PSF1_TEXT_GLYPH_RENDERER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define PSF1_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psf1: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define PSF1_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psf1: next-cycle check failed");

`endif

/* hw/rtl/psf1_pkg.sv */
// Shared types and constants for the glyph renderer
package psf1_pkg;

  localparam int FONT_DEPTH  = 8192;
  localparam int FONT_AW     = 13;
  localparam int GLYPH_WIDTH = 8;

  localparam int GLYPH_COUNT_DEF    = 256;
  localparam int MAX_GLYPH_ROWS_DEF = 32;

  localparam int GROWS_W = 6;
  localparam int SCRW_W  = 12;
  localparam int PPL_W   = 13;
  localparam int ADDR_W  = 32;
  localparam int COLOR_W = 32;
  localparam int CX_W    = 12;
  localparam int CY_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [GROWS_W-1:0] GLYPH_ROWS_RST = 6'd16;
  localparam logic [SCRW_W-1:0]  SCREEN_W_RST   = 12'd640;
  localparam logic [PPL_W-1:0]   PPL_RST        = 13'd640;
  localparam logic [ADDR_W-1:0]  FRAME_BASE_RST = 32'd0;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_DRAW   = 2'd1,
    REQ_CURSOR = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_ROWS = 2'd0,
    CFG_SCREEN_W   = 2'd1,
    CFG_PPL        = 2'd2,
    CFG_FRAME_BASE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_FLUSH
  } state_t;

endpackage

/* hw/rtl/psf1_req_if.sv */
// Request channel: font loads, draws and cursor moves
interface psf1_req_if
  import psf1_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [FONT_AW-1:0] font_addr;
  logic [7:0]         font_byte;
  logic [7:0]         char_code;
  logic [COLOR_W-1:0] pixel_color;
  logic [CX_W-1:0]    cursor_x_in;
  logic [CY_W-1:0]    cursor_y_in;

  modport source (output valid, req_type, font_addr, font_byte, char_code,
                  pixel_color, cursor_x_in, cursor_y_in, input ready);
  modport sink   (input valid, req_type, font_addr, font_byte, char_code,
                  pixel_color, cursor_x_in, cursor_y_in, output ready);
endinterface

/* hw/rtl/psf1_row_if.sv */
// Result channel: masked framebuffer row writes
interface psf1_row_if
  import psf1_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  row_addr;
  logic [7:0]         row_mask;
  logic [COLOR_W-1:0] row_color;
  logic               row_last;

  modport source (output valid, row_addr, row_mask, row_color, row_last, input ready);
  modport sink   (input valid, row_addr, row_mask, row_color, row_last, output ready);
endinterface

/* hw/rtl/psf1_cfg_if.sv */
// Configuration write channel
interface psf1_cfg_if
  import psf1_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/psf1_ram.sv */
// Generic simple dual-port RAM with registered read
module psf1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* hw/rtl/psf1_text_glyph_renderer.sv */
// Top level of the bitmap font glyph renderer
// Draws 8-pixel-wide glyphs from an 8192 x 8 font RAM into a linear framebuffer.
// A font load or cursor move is accepted only while idle. A draw walks the glyph
// rows with one font RAM read and one row-address multiply per cycle while the
// result side does not stall, and holds the request side off until the draw is
// done and its last written row, if any, is in the output register; glyph_rows
// above MAX_GLYPH_ROWS counts as MAX_GLYPH_ROWS. The font RAM has no reset and
// needs no clearing; load a glyph before drawing it.
// Blank rows produce no write; the last write of a character carries row_last.
`include "psf1_text_glyph_renderer_defines.svh"

module psf1_text_glyph_renderer
  import psf1_pkg::*;
#(
  parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  psf1_req_if.sink req,
  psf1_cfg_if.sink cfg,
  psf1_row_if.source row
);
  localparam int ROW_W = $clog2(MAX_GLYPH_ROWS + 1);
  localparam logic [9:0]         GC_10    = 10'(GLYPH_COUNT);
  localparam logic [GROWS_W-1:0] MAX_ROWS = GROWS_W'(MAX_GLYPH_ROWS);

  // configuration
  logic [GROWS_W-1:0] glyph_rows;
  logic [SCRW_W-1:0]  screen_width;
  logic [PPL_W-1:0]   pixels_per_line;
  logic [ADDR_W-1:0]  frame_base;

  // cursor
  logic [CX_W-1:0] cursor_x;
  logic [CY_W-1:0] cursor_y;

  // draw context
  state_t             state, state_next;
  logic [ROW_W-1:0]   rows;
  logic [FONT_AW-1:0] font_base;
  logic [COLOR_W-1:0] color;
  logic [ADDR_W-1:0]  base_xy;
  logic [ROW_W-1:0]   row_cnt;
  logic [ROW_W-1:0]   rd_row;
  logic               rd_valid;
  logic [28:0]        row_prod;
  logic [ADDR_W-1:0]  pend_addr;
  logic [7:0]         pend_mask;
  logic               pend_valid;
  logic               out_valid;

  logic               req_go, draw_go, load_go, cursor_go;
  logic               out_free, chk_hit, stall, issue_go, draw_done;
  logic               load_mid, load_last, finish;
  logic [7:0]         font_rd;
  logic [FONT_AW-1:0] font_rd_addr;
  logic [ROW_W-1:0]   rd_sel;
  logic [CY_W-1:0]    issue_y;
  logic [ADDR_W-1:0]  chk_addr;
  logic [9:0]         code_ext, code_mod;
  logic [15:0]        font_base_full;
  logic [ROW_W-1:0]   rows_sat;
  logic [PPL_W:0]     next_x;

  assign cfg.ready = 1'b1;
  assign req_go    = req.valid && req.ready;
  assign draw_go   = req_go && (req.req_type == REQ_DRAW);
  assign load_go   = req_go && (req.req_type == REQ_LOAD);
  assign cursor_go = req_go && (req.req_type == REQ_CURSOR);

  assign out_free  = !out_valid || row.ready;
  assign chk_hit   = rd_valid && (font_rd != 8'd0);
  assign stall     = chk_hit && pend_valid && !out_free;
  assign rd_sel    = stall ? rd_row : row_cnt;
  assign font_rd_addr = font_base + FONT_AW'(rd_sel);
  assign issue_y   = cursor_y + CY_W'(row_cnt);
  assign chk_addr  = base_xy + ADDR_W'(row_prod);

  assign code_ext  = {2'b00, req.char_code};
  assign code_mod  = (code_ext >= GC_10) ? code_ext - GC_10 : code_ext;
  assign rows_sat  = ROW_W'((glyph_rows > MAX_ROWS) ? MAX_ROWS : glyph_rows);
  assign font_base_full = 16'(code_mod) * 16'(rows_sat);
  assign next_x    = (PPL_W + 1)'(cursor_x) + (PPL_W + 1)'(GLYPH_WIDTH);

  psf1_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk     (clk),
    .wr_en   (load_go),
    .wr_addr (req.font_addr),
    .wr_data (req.font_byte),
    .rd_addr (font_rd_addr),
    .rd_data (font_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (draw_go) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (draw_done) begin
          state_next = pend_valid ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = 1'b0;
    issue_go  = 1'b0;
    draw_done = 1'b0;
    load_mid  = 1'b0;
    load_last = 1'b0;
    finish    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_DRAW: begin
        issue_go  = !stall && (row_cnt < rows);
        draw_done = !rd_valid && (row_cnt >= rows);
        load_mid  = chk_hit && !stall && pend_valid;
        finish    = draw_done && !pend_valid;
      end
      ST_FLUSH: begin
        load_last = out_free;
        finish    = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_rows      <= GLYPH_ROWS_RST;
      screen_width    <= SCREEN_W_RST;
      pixels_per_line <= PPL_RST;
      frame_base      <= FRAME_BASE_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_GLYPH_ROWS: glyph_rows      <= cfg.data[GROWS_W-1:0];
        CFG_SCREEN_W:   screen_width    <= cfg.data[SCRW_W-1:0];
        CFG_PPL:        pixels_per_line <= cfg.data[PPL_W-1:0];
        CFG_FRAME_BASE: frame_base      <= cfg.data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // cursor: place, or advance after a glyph
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (cursor_go) begin
      cursor_x <= req.cursor_x_in;
      cursor_y <= req.cursor_y_in;
    end else if (finish) begin
      if (next_x >= (PPL_W + 1)'(screen_width)) begin
        cursor_x <= '0;
        cursor_y <= cursor_y + CY_W'(rows);
      end else begin
        cursor_x <= next_x[CX_W-1:0];
      end
    end
  end

  // draw context latched at accept
  always_ff @(posedge clk) begin
    if (draw_go) begin
      rows      <= rows_sat;
      font_base <= font_base_full[FONT_AW-1:0];
      color     <= req.pixel_color;
      base_xy   <= frame_base + ADDR_W'(cursor_x);
    end
  end

  // row issue: font read and row offset multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      rd_valid <= 1'b0;
    end else if (draw_go) begin
      row_cnt  <= '0;
      rd_valid <= 1'b0;
    end else if (state == ST_DRAW && !stall) begin
      rd_valid <= issue_go;
      if (issue_go) begin
        row_cnt <= row_cnt + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_go) begin
      rd_row   <= row_cnt;
      row_prod <= 29'(issue_y) * 29'(pixels_per_line);
    end
  end

  // pending row: held until a later row or the end shows whether it is last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (chk_hit && !stall) begin
      pend_valid <= 1'b1;
    end else if (load_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chk_hit && !stall) begin
      pend_addr <= chk_addr;
      pend_mask <= font_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_mid || load_last) begin
      out_valid <= 1'b1;
    end else if (row.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid || load_last) begin
      row.row_addr  <= pend_addr;
      row.row_mask  <= pend_mask;
      row.row_color <= color;
      row.row_last  <= load_last;
    end
  end

  assign row.valid = out_valid;

  `PSF1_ASSERT_NOW(a_idle_no_pend, state == ST_IDLE, !pend_valid && !rd_valid)
  `PSF1_ASSERT_NOW(a_flush_has_pend, state == ST_FLUSH, pend_valid)
  `PSF1_ASSERT_NOW(a_row_in_range, state == ST_DRAW, row_cnt <= rows)
  `PSF1_ASSERT_NEXT(a_mid_not_last, load_mid, out_valid && !row.row_last)
  `PSF1_ASSERT_NEXT(a_flush_last, load_last, out_valid && row.row_last)
endmodule

/* test/tb.sv */
// Self-checking testbench for the glyph renderer: font loads, cursor moves and glyph draws
`timescale 1ns / 100ps

module tb;
  import psf1_pkg::*;

  typedef struct {
    req_t               kind;
    logic [FONT_AW-1:0] faddr;
    logic [7:0]         fbyte;
    logic [7:0]         code;
    logic [COLOR_W-1:0] color;
    logic [CX_W-1:0]    cx;
    logic [CY_W-1:0]    cy;
  } glyph_req_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [7:0]         mask;
    logic [COLOR_W-1:0] color;
    logic               last;
  } row_write_t;

  logic clk = 1'b0;
  logic rst;

  psf1_req_if req_bus ();
  psf1_cfg_if cfg_bus ();
  psf1_row_if row_bus ();

  psf1_text_glyph_renderer dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .cfg (cfg_bus),
    .row (row_bus)
  );

  always #10 clk = ~clk;

  glyph_req_t req_backlog [$];
  row_write_t pending_rows [$];
  glyph_req_t cur_req;
  int         errors = 0;

  logic [7:0]         font_img [FONT_DEPTH];
  bit                 font_loaded [FONT_DEPTH];
  logic [7:0]         code_pool [3];
  logic [CX_W-1:0]    cur_x = '0;
  logic [CY_W-1:0]    cur_y = '0;
  logic [GROWS_W-1:0] cfg_rows = GLYPH_ROWS_RST;
  logic [SCRW_W-1:0]  cfg_width = SCREEN_W_RST;
  logic [PPL_W-1:0]   cfg_pitch = PPL_RST;
  logic [ADDR_W-1:0]  cfg_base = FRAME_BASE_RST;

  int req_idle_pct = 0;
  int row_idle_pct = 0;
  int req_gap = 0;
  int row_gap = 0;
  int long_hold = 0;

  function automatic int unsigned eff_rows();
    return (cfg_rows > MAX_GLYPH_ROWS_DEF) ? MAX_GLYPH_ROWS_DEF : cfg_rows;
  endfunction

  function automatic void render_request(glyph_req_t it);
    int unsigned rows;
    int unsigned nx;
    logic [7:0]  bits;
    logic [CY_W-1:0] y;
    row_write_t  w;
    row_write_t  glyph_rows_out [$];
    rows = eff_rows();
    case (it.kind)
      REQ_LOAD: font_img[it.faddr] = it.fbyte;
      REQ_CURSOR: begin
        cur_x = it.cx;
        cur_y = it.cy;
      end
      REQ_DRAW: begin
        for (int unsigned r = 0; r < rows; r++) begin
          bits = font_img[(int'(it.code) * rows + r) % FONT_DEPTH];
          if (bits != 8'h00) begin
            y = cur_y + CY_W'(r);
            w.addr = cfg_base + ADDR_W'(cur_x) + ADDR_W'(y) * ADDR_W'(cfg_pitch);
            w.mask = bits;
            w.color = it.color;
            w.last = 1'b0;
            glyph_rows_out.push_back(w);
          end
        end
        if (glyph_rows_out.size() > 0)
          glyph_rows_out[glyph_rows_out.size() - 1].last = 1'b1;
        foreach (glyph_rows_out[i]) pending_rows.push_back(glyph_rows_out[i]);
        nx = int'(cur_x) + GLYPH_WIDTH;
        if (nx >= int'(cfg_width)) begin
          cur_x = '0;
          cur_y = cur_y + CY_W'(rows);
        end else begin
          cur_x = CX_W'(nx);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_row_write();
    row_write_t want;
    if (pending_rows.size() == 0) begin
      $error("row write with none expected: row_addr %h row_mask %h", row_bus.row_addr,
             row_bus.row_mask);
      errors++;
      return;
    end
    want = pending_rows.pop_front();
    if (row_bus.row_addr !== want.addr) begin
      $error("row_addr: expected %h, got %h", want.addr, row_bus.row_addr);
      errors++;
    end
    if (row_bus.row_mask !== want.mask) begin
      $error("row_mask: expected %h, got %h", want.mask, row_bus.row_mask);
      errors++;
    end
    if (row_bus.row_color !== want.color) begin
      $error("row_color: expected %h, got %h", want.color, row_bus.row_color);
      errors++;
    end
    if (row_bus.row_last !== want.last) begin
      $error("row_last: expected %b, got %b", want.last, row_bus.row_last);
      errors++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) render_request(cur_req);
      if (!req_bus.valid || req_bus.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_bus.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          cur_req = req_backlog.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.req_type <= cur_req.kind;
          req_bus.font_addr <= cur_req.faddr;
          req_bus.font_byte <= cur_req.fbyte;
          req_bus.char_code <= cur_req.code;
          req_bus.pixel_color <= cur_req.color;
          req_bus.cursor_x_in <= cur_req.cx;
          req_bus.cursor_y_in <= cur_req.cy;
          if ($urandom_range(0, 99) < req_idle_pct) req_gap = $urandom_range(1, 19);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // row write monitor
  always @(posedge clk) begin
    if (rst) begin
      row_bus.ready <= 1'b0;
      row_gap = 0;
    end else begin
      if (row_bus.valid && row_bus.ready) check_row_write();
      if (long_hold != 0) begin
        row_bus.ready <= 1'b0;
      end else if (row_gap > 0) begin
        row_gap--;
        row_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < row_idle_pct) begin
        row_gap = $urandom_range(0, 18);
        row_bus.ready <= 1'b0;
      end else begin
        row_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (long_hold != 0) long_hold <= long_hold - 1;
  end

  function automatic logic [7:0] rand_font_byte();
    case ($urandom_range(0, 7))
      0, 1: return 8'h00;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic glyph_req_t rand_req();
    glyph_req_t it;
    it.kind = req_t'($urandom_range(0, 3));
    it.faddr = FONT_AW'($urandom);
    it.fbyte = 8'($urandom);
    it.code = 8'($urandom);
    it.color = COLOR_W'($urandom);
    it.cx = CX_W'($urandom);
    it.cy = CY_W'($urandom);
    return it;
  endfunction

  function automatic void queue_load(logic [FONT_AW-1:0] a, logic [7:0] b);
    glyph_req_t it;
    it = rand_req();
    it.kind = REQ_LOAD;
    it.faddr = a;
    it.fbyte = b;
    font_loaded[a] = 1'b1;
    req_backlog.push_back(it);
  endfunction

  function automatic void queue_cursor(logic [CX_W-1:0] x, logic [CY_W-1:0] y);
    glyph_req_t it;
    it = rand_req();
    it.kind = REQ_CURSOR;
    it.cx = x;
    it.cy = y;
    req_backlog.push_back(it);
  endfunction

  // load any glyph rows not yet written, then draw
  function automatic void queue_draw(logic [7:0] code, logic [COLOR_W-1:0] color, bit blank);
    int unsigned rows;
    int unsigned a;
    glyph_req_t  it;
    rows = eff_rows();
    for (int unsigned r = 0; r < rows; r++) begin
      a = (int'(code) * rows + r) % FONT_DEPTH;
      if (!font_loaded[a]) queue_load(FONT_AW'(a), blank ? 8'h00 : rand_font_byte());
    end
    it = rand_req();
    it.kind = REQ_DRAW;
    it.code = code;
    it.color = color;
    req_backlog.push_back(it);
  endfunction

  function automatic void random_phase(int n);
    logic [CX_W-1:0] x;
    logic [CY_W-1:0] y;
    glyph_req_t      it;
    int              pick;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick <= 12) begin
        queue_draw(code_pool[$urandom_range(0, 2)], rand_color(), $urandom_range(0, 5) == 0);
      end else if (pick <= 15) begin
        queue_load(FONT_AW'($urandom), rand_font_byte());
      end else if (pick <= 18) begin
        case ($urandom_range(0, 3))
          0: x = CX_W'($urandom);
          1: x = (cfg_width > 8) ? cfg_width - CX_W'($urandom_range(0, 8)) : '0;
          2: x = '1;
          default: x = CX_W'($urandom_range(0, 64));
        endcase
        y = ($urandom_range(0, 2) == 0) ? 16'hFFFF - 16'($urandom_range(0, 40))
                                        : CY_W'($urandom);
        queue_cursor(x, y);
      end else begin
        it = rand_req();
        it.kind = REQ_NONE;
        req_backlog.push_back(it);
      end
    end
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    while ((req_backlog.size() != 0 || req_bus.valid || pending_rows.size() != 0)
           && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    if (guard >= 200000) begin
      $error("row writes still expected after drain: %0d", pending_rows.size());
      errors++;
    end
    repeat (48) @(posedge clk);
  endtask

  task automatic program_regs(logic [GROWS_W-1:0] rows, logic [SCRW_W-1:0] sw,
                              logic [PPL_W-1:0] ppl, logic [ADDR_W-1:0] base);
    cfg_idx_t               order [4] = '{CFG_GLYPH_ROWS, CFG_SCREEN_W, CFG_PPL, CFG_FRAME_BASE};
    logic [CFG_DATA_W-1:0]  vals [4];
    vals = '{CFG_DATA_W'(rows), CFG_DATA_W'(sw), CFG_DATA_W'(ppl), CFG_DATA_W'(base)};
    for (int i = 0; i < 4; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= order[i];
      cfg_bus.data <= vals[i];
      do @(posedge clk); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
    cfg_rows = rows;
    cfg_width = sw;
    cfg_pitch = ppl;
    cfg_base = base;
  endtask

  task automatic run_phase(logic [GROWS_W-1:0] rows, logic [SCRW_W-1:0] sw,
                           logic [PPL_W-1:0] ppl, logic [ADDR_W-1:0] base,
                           int req_pct, int row_pct, int n);
    wait_drained();
    program_regs(rows, sw, ppl, base);
    @(negedge clk);
    req_idle_pct = req_pct;
    row_idle_pct = row_pct;
    random_phase(n);
  endtask

  initial begin
    logic [7:0] shape [16];
    glyph_req_t it;
    shape = '{8'h00, 8'h18, 8'h24, 8'h42, 8'h42, 8'h7E, 8'h42, 8'h42,
              8'h42, 8'h00, 8'h80, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00};
    code_pool = '{8'h00, 8'hFF, 8'($urandom)};
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_NONE;
    req_bus.font_addr = '0;
    req_bus.font_byte = '0;
    req_bus.char_code = '0;
    req_bus.pixel_color = '0;
    req_bus.cursor_x_in = '0;
    req_bus.cursor_y_in = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_GLYPH_ROWS;
    cfg_bus.data = '0;
    row_bus.ready = 1'b0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: one glyph with blank rows, colour extremes, wraps
    req_idle_pct = 10;
    row_idle_pct = 10;
    for (int r = 0; r < 16; r++) queue_load(FONT_AW'(8'h41 * 16 + r), shape[r]);
    queue_draw(8'h41, '0, 1'b0);
    queue_draw(8'h41, '1, 1'b0);
    queue_cursor('1, '1);
    queue_draw(8'h41, 32'h1234_5678, 1'b0);
    it = rand_req();
    it.kind = REQ_NONE;
    req_backlog.push_back(it);
    queue_cursor(CX_W'(632), '0);
    queue_draw(8'h41, 32'hA5A5_5A5A, 1'b0);
    queue_draw(8'h41, 32'h0F0F_F0F0, 1'b0);

    run_phase(6'd8, 12'd64, 13'd64, 32'h0000_1000, 10, 10, 12);
    run_phase(6'd32, 12'd4095, 13'd8191, 32'hFFFF_FF00, 0, 0, 12);
    run_phase(6'd1, 12'd8, 13'd8, 32'h0000_0000, 30, 30, 12);
    run_phase(6'd0, 12'd640, 13'd640, 32'd123, 10, 10, 12);
    run_phase(6'd63, 12'd320, 13'd1000, 32'($urandom), 15, 5, 12);
    run_phase(6'd5, 12'd0, 13'd333, 32'($urandom), 5, 15, 12);
    repeat (2) begin
      run_phase(6'($urandom_range(1, 16)), 12'($urandom_range(8, 4095)),
                13'($urandom_range(8, 8191)), 32'($urandom), 10, 10, 12);
    end

    // hold the result side off while draws keep coming
    wait_drained();
    program_regs(6'd16, 12'd640, 13'd640, 32'h0000_0000);
    @(negedge clk);
    req_idle_pct = 0;
    row_idle_pct = 0;
    long_hold = 400;
    for (int i = 0; i < 20; i++) queue_draw(code_pool[$urandom_range(0, 2)], rand_color(), 1'b0);

    run_phase(6'($urandom_range(1, 16)), 12'($urandom_range(8, 4095)),
              13'($urandom_range(8, 8191)), 32'($urandom), 0, 0, 12);
    wait_drained();

    if (errors == 0) begin
      $display("** psf1_text_glyph_renderer: PASSED **");
    end else begin
      $display("** psf1_text_glyph_renderer: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** psf1_text_glyph_renderer: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/psf1_pkg.sv
hw/rtl/psf1_req_if.sv
hw/rtl/psf1_row_if.sv
hw/rtl/psf1_cfg_if.sv
hw/rtl/psf1_ram.sv
hw/rtl/psf1_text_glyph_renderer.sv
test/tb.sv
